// ===== rtl/core/spni_pkg.sv =====
// Shared constants, types and the neighborhood offset table for the neighbor index pipeline.
package spni_pkg;

	localparam int GRID_BITS       = 12;
	localparam int CODE_BITS       = 4;
	localparam int INDEX_WIDTH_DEF = 24;
	localparam int WORK_BITS       = 2 * GRID_BITS;
	localparam int DIV_STEPS       = 3;
	localparam int DIV_STAGES      = GRID_BITS / DIV_STEPS;

	typedef enum logic {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic signed [3:0] drow;
		logic signed [1:0] dcol;
	} offset_t;

	typedef struct packed {
		logic    valid;
		logic    skip;
		offset_t off;
	} side_t;

	function automatic offset_t code_offset(input logic [CODE_BITS-1:0] code);
		offset_t o;
		case (code)
			4'd0:    o = '{drow: -4'sd1, dcol: -2'sd1};
			4'd1:    o = '{drow: -4'sd1, dcol:  2'sd0};
			4'd2:    o = '{drow: -4'sd1, dcol:  2'sd1};
			4'd3:    o = '{drow:  4'sd0, dcol: -2'sd1};
			4'd4:    o = '{drow:  4'sd0, dcol:  2'sd0};
			4'd5:    o = '{drow:  4'sd0, dcol:  2'sd1};
			4'd6:    o = '{drow:  4'sd1, dcol: -2'sd1};
			4'd7:    o = '{drow:  4'sd1, dcol:  2'sd0};
			4'd8:    o = '{drow:  4'sd1, dcol:  2'sd1};
			4'd9:    o = '{drow:  4'sd2, dcol: -2'sd1};
			4'd10:   o = '{drow:  4'sd2, dcol:  2'sd0};
			4'd11:   o = '{drow:  4'sd2, dcol:  2'sd1};
			4'd12:   o = '{drow:  4'sd3, dcol: -2'sd1};
			4'd13:   o = '{drow:  4'sd3, dcol:  2'sd0};
			4'd14:   o = '{drow:  4'sd3, dcol:  2'sd1};
			default: o = '{drow:  4'sd4, dcol: -2'sd1};
		endcase
		return o;
	endfunction

endpackage

// ===== rtl/core/superpixel_neighbor_index.sv =====
// Top level of the superpixel 3x3 neighbor index pipeline.
// Throughput: one request per cycle; busy stays low, the receiver cannot stall.
// Stages: two front, four divider with three quotient bits each, two back.
// Reset: grid width and height return to 1, all pipeline valid bits clear.
module superpixel_neighbor_index #(
	parameter int INDEX_WIDTH = spni_pkg::INDEX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [INDEX_WIDTH-1:0]       home_index,
	input  logic [spni_pkg::CODE_BITS-1:0]      neighbor_code,
	output logic                                done,
	output logic [INDEX_WIDTH-1:0]              neighbor_index,
	output logic                                skipped,
	input  logic                                cfg_write,
	input  logic                                cfg_index,
	input  logic [spni_pkg::GRID_BITS-1:0]      cfg_data
);

	localparam int NS = spni_pkg::DIV_STAGES;

	logic [spni_pkg::GRID_BITS-1:0] grid_width_q;
	logic [spni_pkg::GRID_BITS-1:0] grid_height_q;

	spni_pkg::side_t                side_d [0:NS];
	logic signed [INDEX_WIDTH-1:0]  home_d [0:NS];
	logic [spni_pkg::WORK_BITS-1:0] rem_d  [0:NS];
	logic [spni_pkg::GRID_BITS-1:0] quo_d  [0:NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= spni_pkg::GRID_BITS'(1);
			grid_height_q <= spni_pkg::GRID_BITS'(1);
		end else if (cfg_write) begin
			case (spni_pkg::reg_index_t'(cfg_index))
				spni_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				spni_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	spni_front #(
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.home_index    (home_index),
		.neighbor_code (neighbor_code),
		.grid_width    (grid_width_q),
		.grid_height   (grid_height_q),
		.side_out      (side_d[0]),
		.home_out      (home_d[0])
	);

	assign rem_d[0] = spni_pkg::WORK_BITS'($unsigned(home_d[0]));
	assign quo_d[0] = '0;

	for (genvar i = 0; i < NS; i++) begin : g_div
		spni_div_stage #(
			.INDEX_WIDTH (INDEX_WIDTH),
			.TOP_BIT     (spni_pkg::GRID_BITS - 1 - i * spni_pkg::DIV_STEPS)
		) u_stage (
			.clk        (clk),
			.arst_n     (arst_n),
			.side_in    (side_d[i]),
			.home_in    (home_d[i]),
			.rem_in     (rem_d[i]),
			.quo_in     (quo_d[i]),
			.grid_width (grid_width_q),
			.side_out   (side_d[i+1]),
			.home_out   (home_d[i+1]),
			.rem_out    (rem_d[i+1]),
			.quo_out    (quo_d[i+1])
		);
	end

	spni_back #(
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.side_in        (side_d[NS]),
		.home_in        (home_d[NS]),
		.rem_in         (rem_d[NS]),
		.quo_in         (quo_d[NS]),
		.grid_width     (grid_width_q),
		.grid_height    (grid_height_q),
		.done           (done),
		.neighbor_index (neighbor_index),
		.skipped        (skipped)
	);

endmodule

// ===== rtl/core/spni_front.sv =====
// Input capture, grid size product, skip test and neighborhood offset lookup.
module spni_front #(
	parameter int INDEX_WIDTH = spni_pkg::INDEX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [INDEX_WIDTH-1:0]       home_index,
	input  logic [spni_pkg::CODE_BITS-1:0]      neighbor_code,
	input  logic [spni_pkg::GRID_BITS-1:0]      grid_width,
	input  logic [spni_pkg::GRID_BITS-1:0]      grid_height,
	output spni_pkg::side_t                     side_out,
	output logic signed [INDEX_WIDTH-1:0]       home_out
);

	localparam int CMP_BITS = (INDEX_WIDTH > spni_pkg::WORK_BITS) ?
		INDEX_WIDTH : spni_pkg::WORK_BITS;

	logic [spni_pkg::WORK_BITS-1:0]  size_q;
	spni_pkg::side_t                 side_s1;
	logic signed [INDEX_WIDTH-1:0]   home_s1;
	spni_pkg::side_t                 side_s2;
	logic signed [INDEX_WIDTH-1:0]   home_s2;
	logic                            skip_c;

	always_ff @(posedge clk) begin
		size_q <= spni_pkg::WORK_BITS'(grid_width) * spni_pkg::WORK_BITS'(grid_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1.valid <= start;
			side_s1.skip  <= 1'b0;
			side_s1.off   <= spni_pkg::code_offset(neighbor_code);
		end
	end

	always_ff @(posedge clk) begin
		home_s1 <= home_index;
	end

	assign skip_c = home_s1[INDEX_WIDTH-1] ||
		(CMP_BITS'($unsigned(home_s1)) >= CMP_BITS'(size_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else begin
			side_s2.valid <= side_s1.valid;
			side_s2.skip  <= skip_c;
			side_s2.off   <= side_s1.off;
		end
	end

	always_ff @(posedge clk) begin
		home_s2 <= home_s1;
	end

	assign side_out = side_s2;
	assign home_out = home_s2;

endmodule

// ===== rtl/core/spni_div_stage.sv =====
// One registered stage of the restoring divider: a few quotient bits per stage.
module spni_div_stage #(
	parameter int INDEX_WIDTH = spni_pkg::INDEX_WIDTH_DEF,
	parameter int TOP_BIT     = spni_pkg::GRID_BITS - 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  spni_pkg::side_t                     side_in,
	input  logic signed [INDEX_WIDTH-1:0]       home_in,
	input  logic [spni_pkg::WORK_BITS-1:0]      rem_in,
	input  logic [spni_pkg::GRID_BITS-1:0]      quo_in,
	input  logic [spni_pkg::GRID_BITS-1:0]      grid_width,
	output spni_pkg::side_t                     side_out,
	output logic signed [INDEX_WIDTH-1:0]       home_out,
	output logic [spni_pkg::WORK_BITS-1:0]      rem_out,
	output logic [spni_pkg::GRID_BITS-1:0]      quo_out
);

	logic [spni_pkg::WORK_BITS-1:0] rem_c;
	logic [spni_pkg::GRID_BITS-1:0] quo_c;
	logic [spni_pkg::WORK_BITS-1:0] divisor_c;

	spni_pkg::side_t                side_s1;
	logic signed [INDEX_WIDTH-1:0]  home_s1;
	logic [spni_pkg::WORK_BITS-1:0] rem_s1;
	logic [spni_pkg::GRID_BITS-1:0] quo_s1;

	always_comb begin
		rem_c     = rem_in;
		quo_c     = quo_in;
		divisor_c = '0;
		for (int k = 0; k < spni_pkg::DIV_STEPS; k++) begin
			divisor_c = spni_pkg::WORK_BITS'(grid_width) << (TOP_BIT - k);
			if (rem_c >= divisor_c) begin
				rem_c              = rem_c - divisor_c;
				quo_c[TOP_BIT - k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1 <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		home_s1 <= home_in;
		rem_s1  <= rem_c;
		quo_s1  <= quo_c;
	end

	assign side_out = side_s1;
	assign home_out = home_s1;
	assign rem_out  = rem_s1;
	assign quo_out  = quo_s1;

endmodule

// ===== rtl/core/spni_back.sv =====
// Neighbor offset, in-grid test, linear index rebuild and result register.
module spni_back #(
	parameter int INDEX_WIDTH = spni_pkg::INDEX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  spni_pkg::side_t                     side_in,
	input  logic signed [INDEX_WIDTH-1:0]       home_in,
	input  logic [spni_pkg::WORK_BITS-1:0]      rem_in,
	input  logic [spni_pkg::GRID_BITS-1:0]      quo_in,
	input  logic [spni_pkg::GRID_BITS-1:0]      grid_width,
	input  logic [spni_pkg::GRID_BITS-1:0]      grid_height,
	output logic                                done,
	output logic [INDEX_WIDTH-1:0]              neighbor_index,
	output logic                                skipped
);

	localparam int RC_BITS  = spni_pkg::GRID_BITS + 2;
	localparam int LIN_BITS = spni_pkg::WORK_BITS + 1;

	logic signed [RC_BITS-1:0]      row_c;
	logic signed [RC_BITS-1:0]      col_c;
	logic                           in_grid_c;

	logic                           valid_s1;
	logic                           skip_s1;
	logic                           in_grid_s1;
	logic [spni_pkg::GRID_BITS-1:0] row_s1;
	logic [spni_pkg::GRID_BITS-1:0] col_s1;
	logic [INDEX_WIDTH-1:0]         home_s1;

	logic [LIN_BITS-1:0]            lin_c;
	logic [INDEX_WIDTH-1:0]         result_c;

	logic                           valid_s2;
	logic                           skip_s2;
	logic [INDEX_WIDTH-1:0]         result_s2;

	assign row_c = $signed({2'b00, quo_in}) + RC_BITS'(side_in.off.drow);
	assign col_c = $signed({2'b00, rem_in[spni_pkg::GRID_BITS-1:0]}) +
		RC_BITS'(side_in.off.dcol);

	assign in_grid_c = !row_c[RC_BITS-1] && (row_c < $signed({2'b00, grid_height})) &&
		!col_c[RC_BITS-1] && (col_c < $signed({2'b00, grid_width}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= side_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		skip_s1    <= side_in.skip;
		in_grid_s1 <= in_grid_c;
		row_s1     <= row_c[spni_pkg::GRID_BITS-1:0];
		col_s1     <= col_c[spni_pkg::GRID_BITS-1:0];
		home_s1    <= $unsigned(home_in);
	end

	assign lin_c = LIN_BITS'(row_s1) * LIN_BITS'(grid_width) + LIN_BITS'(col_s1);

	always_comb begin
		if (skip_s1) begin
			result_c = '0;
		end else if (in_grid_s1) begin
			result_c = INDEX_WIDTH'(lin_c);
		end else begin
			result_c = home_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		skip_s2   <= skip_s1;
		result_s2 <= result_c;
	end

	assign done           = valid_s2;
	assign neighbor_index = result_s2;
	assign skipped        = skip_s2;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the superpixel 3x3 neighbor index pipeline.
`timescale 1ns / 1ps

module tb_top;

	localparam int     IW       = 24;
	localparam int     LATENCY  = 8;
	localparam int     LIMIT    = 200000;
	localparam longint MAX_HOME = (longint'(1) << (IW - 1)) - 1;

	typedef struct packed {
		logic signed [IW-1:0]           home;
		logic [spni_pkg::CODE_BITS-1:0] code;
	} neighbor_req_t;

	typedef struct packed {
		logic [IW-1:0] index;
		logic          skip;
	} neighbor_res_t;

	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           start         = 1'b0;
	logic                           busy;
	logic signed [IW-1:0]           home_index    = '0;
	logic [spni_pkg::CODE_BITS-1:0] neighbor_code = '0;
	logic                           done;
	logic [IW-1:0]                  neighbor_index;
	logic                           skipped;
	logic                           cfg_write     = 1'b0;
	spni_pkg::reg_index_t           cfg_index     = spni_pkg::REG_GRID_WIDTH;
	logic [spni_pkg::GRID_BITS-1:0] cfg_data      = '0;

	neighbor_req_t          requests_q[$];
	neighbor_res_t          expected_q[$];
	neighbor_req_t          next_req;
	neighbor_res_t          exp_res;

	logic [spni_pkg::GRID_BITS-1:0] grid_w = spni_pkg::GRID_BITS'(1);
	logic [spni_pkg::GRID_BITS-1:0] grid_h = spni_pkg::GRID_BITS'(1);
	int                     idle_pct;
	int                     fail_count;
	int                     n_accepted;
	int                     n_checked;
	int                     n_skipped;
	int                     n_settings;
	int                     cycle_count;

	superpixel_neighbor_index #(.INDEX_WIDTH(IW)) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.home_index     (home_index),
		.neighbor_code  (neighbor_code),
		.done           (done),
		.neighbor_index (neighbor_index),
		.skipped        (skipped),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic neighbor_res_t predict_neighbor(input logic signed [IW-1:0] home,
			input logic [spni_pkg::CODE_BITS-1:0] code);
		neighbor_res_t r;
		longint        h_v;
		longint        w;
		longint        ht;
		longint        size;
		longint        row;
		longint        col;
		longint        c;
		longint        idx;
		w    = grid_w;
		ht   = grid_h;
		size = w * ht;
		h_v  = home;
		c    = code;
		r    = '0;
		if (h_v < 0 || h_v >= size) begin
			r.skip = 1'b1;
		end else begin
			row = h_v / w + (c / 3 - 1);
			col = h_v % w + (c % 3 - 1);
			if (row < 0 || row >= ht || col < 0 || col >= w)
				idx = h_v;
			else
				idx = row * w + col;
			r.index = idx[IW-1:0];
		end
		return r;
	endfunction

	function automatic neighbor_req_t random_request();
		neighbor_req_t r;
		longint        w;
		longint        ht;
		longint        size;
		longint        v;
		int            sel;
		w    = grid_w;
		ht   = grid_h;
		size = w * ht;
		sel  = $urandom_range(99);
		if ($urandom_range(4) == 0)
			r.code = spni_pkg::CODE_BITS'($urandom_range(15));
		else
			r.code = spni_pkg::CODE_BITS'($urandom_range(8));
		if (size > 0 && sel < 70) begin
			if ($urandom_range(3) == 0)
				v = ($urandom_range(1) ? ht - 1 : 0) * w + ($urandom_range(1) ? w - 1 : 0);
			else
				v = longint'($urandom_range(ht - 1)) * w + $urandom_range(w - 1);
			if (v > MAX_HOME)
				v = v & MAX_HOME;
		end else if (sel < 85) begin
			if ($urandom_range(1))
				v = size - 2 + $urandom_range(3);
			else
				v = -1 - longint'($urandom_range(2));
			if (v > MAX_HOME)
				v = $urandom_range(MAX_HOME);
		end else begin
			v = $urandom;
		end
		r.home = v[IW-1:0];
		return r;
	endfunction

	task automatic push_request(input int home, input int code);
		requests_q.push_back('{home: home[IW-1:0], code: code[spni_pkg::CODE_BITS-1:0]});
	endtask

	task automatic drain();
		@(negedge clk);
		while (requests_q.size() != 0 || start || expected_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_grid(input int w, input int h);
		drain();
		repeat (LATENCY) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= spni_pkg::REG_GRID_WIDTH;
		cfg_data  <= w[spni_pkg::GRID_BITS-1:0];
		@(posedge clk);
		cfg_index <= spni_pkg::REG_GRID_HEIGHT;
		cfg_data  <= h[spni_pkg::GRID_BITS-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
		grid_w = w[spni_pkg::GRID_BITS-1:0];
		grid_h = h[spni_pkg::GRID_BITS-1:0];
		n_settings++;
		@(negedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start         <= 1'b0;
			home_index    <= '0;
			neighbor_code <= '0;
		end else begin
			if (start && !busy) begin
				expected_q.push_back(predict_neighbor(home_index, neighbor_code));
				n_accepted++;
			end
			if (!start || !busy) begin
				if (requests_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					next_req = requests_q.pop_front();
					start         <= 1'b1;
					home_index    <= next_req.home;
					neighbor_code <= next_req.code;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result: neighbor_index %0d, skipped %0b",
					neighbor_index, skipped);
				fail_count++;
			end else begin
				exp_res = expected_q.pop_front();
				n_checked++;
				if (skipped)
					n_skipped++;
				if (neighbor_index !== exp_res.index) begin
					$error("neighbor_index: expected %0d, got %0d", exp_res.index, neighbor_index);
					fail_count++;
				end
				if (skipped !== exp_res.skip) begin
					$error("skipped: expected %0b, got %0b", exp_res.skip, skipped);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int pw[11];
		int ph[11];
		idle_pct = 22;
		pw = '{1, 4095, 4095, 1, 5, 0, 2, 9, 0, 0, 3};
		ph = '{4095, 4095, 1, 1, 3, 9, 2, 0, 0, 0, 7};
		pw[8] = $urandom_range(40, 1);
		ph[8] = $urandom_range(40, 1);
		pw[9] = $urandom_range(4095, 1);
		ph[9] = $urandom_range(4095, 1);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single-cell grid after reset
		for (int c = 0; c < 9; c++)
			push_request(0, c);
		push_request(1, 4);
		push_request(-1, 4);
		push_request(-8388608, 0);
		push_request(8388607, 8);

		write_grid(3, 3);
		push_request(4, 9);
		push_request(4, 15);
		push_request(4, 12);
		push_request(8, 0);
		push_request(0, 8);

		// zero-sized grid
		write_grid(0, 3);
		push_request(0, 4);
		push_request(5, 4);

		for (int p = 0; p < 11; p++) begin
			if (p == 4)
				idle_pct = 85;
			else if (p == 8)
				idle_pct = 0;
			write_grid(pw[p], ph[p]);
			for (int n = 0; n < 50; n++) begin
				requests_q.push_back(random_request());
				if (p == 6 && n == 25)
					drain();
			end
		end

		drain();
		repeat (2 * LATENCY) @(posedge clk);
		$display("covered %0d requests and %0d results over %0d grid settings", n_accepted,
			n_checked, n_settings);
		$display("including %0d skipped, zero-sized and extreme grids, codes 9 to 15",
			n_skipped);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
